// ===== rtl/mspi_pkg.sv =====
// Package for the motor speed PI loop: loop constants, widths and the
// sequencer state type. No dependencies.

package mspi_pkg;

    // Loop constants.
    localparam int FILTER_SHIFT     = 4;
    localparam int ERROR_SHIFT      = 4;
    localparam int SPEED_SCALE      = 2000;
    localparam int SENSOR_DIRECTION = 1;
    localparam int ERROR_LIMIT      = 100000;
    localparam int OUT_MAX          = 32767;
    localparam int SAT32            = 2147483647;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_MODE_ON     = 3'd0,
        REG_SPEED_TARGET      = 3'd1,
        REG_CURRENT_LIMIT     = 3'd2,
        REG_PROP_GAIN         = 3'd3,
        REG_INTEG_GAIN        = 3'd4,
        REG_LOOP_DIVIDER      = 3'd5,
        REG_POSITION_DEADBAND = 3'd6,
        REG_ZERO_SNAP         = 3'd7
    } mspi_reg_t;

    // Sequencer around the shared multiplier.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SCALE,
        ST_SAT,
        ST_FILT1,
        ST_FILT2,
        ST_ERR1,
        ST_ERR2,
        ST_PMUL,
        ST_IMUL,
        ST_AW,
        ST_IMUL2,
        ST_OUT,
        ST_DONE
    } mspi_state_t;

    // Operand selection for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SCALE,
        MUL_PROP,
        MUL_INEW,
        MUL_INTEG
    } mspi_mul_sel_t;

endpackage

// ===== rtl/motor_speed_pi_loop_core.sv =====
// Top level of the motor speed PI loop: speed estimate, filter and PI with
// conditional anti-windup, computed over one shared multiplier. Uses mspi_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  input    | s_valid / s_ready  | s_rotor_position
//  result   | m_valid / m_ready  | m_q_current_ref, m_speed_estimate, m_loop_ran
//  config   | cfg_we             | cfg_index, cfg_data
//
// A skipped tick goes from idle straight to the done state; a loop tick steps
// through the delta, scale, saturate and filter states and, with speed mode on,
// the error, PI and anti-windup states, around the one 34 x 17 bit multiplier.
// The input is ready only while the sequencer is idle; a held result in the
// output register does not block the next input transfer.
// Reset (aresetn, synchronous) clears all loop state; loop_divider resets to 10.

module motor_speed_pi_loop_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_rotor_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [15:0]                  m_q_current_ref,
    output logic signed [31:0]                  m_speed_estimate,
    output logic                                m_loop_ran,
    input  logic                                cfg_we,
    input  logic [mspi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mspi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mspi_pkg::*;

    localparam logic signed [50:0] SAT51  = 51'(SAT32);
    localparam logic signed [33:0] SAT34  = 34'(SAT32);
    localparam logic signed [33:0] ELIM34 = 34'(ERROR_LIMIT);
    localparam logic signed [33:0] OMAX34 = 34'(OUT_MAX);
    localparam logic signed [16:0] OMAX17 = 17'(OUT_MAX);
    localparam logic signed [16:0] SCALE17 = 17'(SPEED_SCALE);

    function automatic logic signed [33:0] shift_sym(input logic signed [33:0] v,
                                                     input int sh);
        logic signed [33:0] mag;
        begin
            mag = -v;
            if (v >= 0) begin
                shift_sym = v >>> sh;
            end else begin
                shift_sym = -(mag >>> sh);
            end
        end
    endfunction

    // Configuration registers.
    logic                speed_mode_on_reg;
    logic signed [31:0]  speed_target_reg;
    logic [14:0]         current_limit_reg;
    logic [14:0]         prop_gain_reg;
    logic [14:0]         integ_gain_reg;
    logic [15:0]         loop_divider_reg;
    logic [15:0]         deadband_reg;
    logic [15:0]         zero_snap_reg;

    // Loop state.
    mspi_state_t         state_reg, state_next;
    logic [15:0]         tick_reg;
    logic [31:0]         last_pos_reg;
    logic signed [31:0]  filt_reg;
    logic signed [15:0]  integ_reg;
    logic signed [15:0]  held_reg;

    // Work registers.
    logic [31:0]         pos_reg;
    logic                ran_reg;
    logic signed [32:0]  ctrl_reg;
    logic                dead_reg;
    logic signed [31:0]  raw_reg;
    logic signed [33:0]  step_reg;
    logic signed [31:0]  err_reg;
    logic signed [15:0]  es_reg;
    logic signed [15:0]  inew_reg;
    logic signed [31:0]  p_reg;
    logic signed [50:0]  prod_reg;

    // Output register.
    logic                m_valid_reg;
    logic signed [15:0]  m_qref_reg;
    logic signed [31:0]  m_speed_reg;
    logic                m_ran_reg;

    // Control.
    mspi_mul_sel_t       mul_sel;
    logic                in_xfer;
    logic                out_load;
    logic                run_tick;
    logic [15:0]         tick_inc;

    // Datapath nets.
    logic signed [33:0]  mul_a;
    logic signed [16:0]  mul_b;
    logic [31:0]         delta32;
    logic signed [32:0]  ctrl;
    logic signed [32:0]  db33;
    logic                dead;
    logic signed [31:0]  raw_sat;
    logic signed [33:0]  diff34;
    logic signed [33:0]  fsum;
    logic signed [31:0]  fnew;
    logic signed [33:0]  zs34;
    logic signed [33:0]  err34;
    logic signed [31:0]  err_clamped;
    logic signed [33:0]  es_shift;
    logic signed [15:0]  es_clamped;
    logic signed [16:0]  isum;
    logic signed [15:0]  inew;
    logic signed [32:0]  unc;
    logic signed [32:0]  lim33;
    logic                over, under, keep;
    logic signed [15:0]  out_clamped;

    assign tick_inc = tick_reg + 16'd1;
    assign run_tick = (tick_inc >= loop_divider_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = run_tick ? ST_DELTA : ST_DONE;
            ST_DELTA: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SAT;
            ST_SAT:   state_next = ST_FILT1;
            ST_FILT1: state_next = ST_FILT2;
            ST_FILT2: state_next = speed_mode_on_reg ? ST_ERR1 : ST_DONE;
            ST_ERR1:  state_next = ST_ERR2;
            ST_ERR2:  state_next = ST_PMUL;
            ST_PMUL:  state_next = ST_IMUL;
            ST_IMUL:  state_next = ST_AW;
            ST_AW:    state_next = ST_IMUL2;
            ST_IMUL2: state_next = ST_OUT;
            ST_OUT:   state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        mul_sel  = MUL_NONE;
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_SCALE: mul_sel = MUL_SCALE;
            ST_PMUL:  mul_sel = MUL_PROP;
            ST_IMUL:  mul_sel = MUL_INEW;
            ST_IMUL2: mul_sel = MUL_INTEG;
            ST_DONE:  out_load = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    assign in_xfer = s_valid && s_ready;

    // Shared multiplier operands.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mul_sel)
            MUL_SCALE: begin
                mul_a = 34'(ctrl_reg);
                mul_b = SCALE17;
            end
            MUL_PROP: begin
                mul_a = 34'(es_reg);
                mul_b = signed'({2'b00, prop_gain_reg});
            end
            MUL_INEW: begin
                mul_a = 34'(inew_reg);
                mul_b = signed'({2'b00, integ_gain_reg});
            end
            MUL_INTEG: begin
                mul_a = 34'(integ_reg);
                mul_b = signed'({2'b00, integ_gain_reg});
            end
            default: ;
        endcase
    end

    // Speed estimate arithmetic.
    always_comb begin
        delta32 = pos_reg - last_pos_reg;
        if (SENSOR_DIRECTION > 0) begin
            ctrl = signed'({delta32[31], delta32});
        end else if (SENSOR_DIRECTION < 0) begin
            ctrl = -signed'({delta32[31], delta32});
        end else begin
            ctrl = '0;
        end
        db33 = signed'({17'b0, deadband_reg});
        dead = (ctrl <= db33) && (ctrl >= -db33);

        if (prod_reg > SAT51) begin
            raw_sat = 32'(SAT32);
        end else if (prod_reg < -SAT51) begin
            raw_sat = -32'(SAT32);
        end else begin
            raw_sat = prod_reg[31:0];
        end

        diff34 = 34'(raw_reg) - 34'(filt_reg);

        fsum = 34'(filt_reg) + step_reg;
        if (fsum > SAT34) begin
            fnew = 32'(SAT32);
        end else if (fsum < -SAT34) begin
            fnew = -32'(SAT32);
        end else begin
            fnew = fsum[31:0];
        end
        zs34 = signed'({18'b0, zero_snap_reg});
        if ((34'(fnew) <= zs34) && (34'(fnew) >= -zs34)) begin
            fnew = '0;
        end
    end

    // PI arithmetic.
    always_comb begin
        err34 = 34'(speed_target_reg) - 34'(filt_reg);
        if (err34 > ELIM34) begin
            err_clamped = 32'(ERROR_LIMIT);
        end else if (err34 < -ELIM34) begin
            err_clamped = -32'(ERROR_LIMIT);
        end else begin
            err_clamped = err34[31:0];
        end

        es_shift = shift_sym(34'(err_reg), ERROR_SHIFT);
        if (es_shift > OMAX34) begin
            es_clamped = 16'(OUT_MAX);
        end else if (es_shift < -OMAX34) begin
            es_clamped = -16'(OUT_MAX);
        end else begin
            es_clamped = es_shift[15:0];
        end

        isum = 17'(integ_reg) + 17'(es_reg);
        if (isum > OMAX17) begin
            inew = 16'(OUT_MAX);
        end else if (isum < -OMAX17) begin
            inew = -16'(OUT_MAX);
        end else begin
            inew = isum[15:0];
        end

        // Both products fit in 31 bits, so their sum fits in 33.
        unc   = 33'(p_reg) + signed'(prod_reg[32:0]);
        lim33 = signed'({18'b0, current_limit_reg});
        over  = unc > lim33;
        under = unc < -lim33;
        keep  = !(over || under) || (integ_gain_reg == '0) ||
                (over && es_reg < 0) || (under && es_reg > 0);
        if (over) begin
            out_clamped = signed'({1'b0, current_limit_reg});
        end else if (under) begin
            out_clamped = -signed'({1'b0, current_limit_reg});
        end else begin
            out_clamped = unc[15:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_mode_on_reg <= 1'b0;
            speed_target_reg  <= '0;
            current_limit_reg <= '0;
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            loop_divider_reg  <= 16'd10;
            deadband_reg      <= '0;
            zero_snap_reg     <= '0;
        end else if (cfg_we) begin
            case (mspi_reg_t'(cfg_index))
                REG_SPEED_MODE_ON:     speed_mode_on_reg <= cfg_data[0];
                REG_SPEED_TARGET:      speed_target_reg  <= signed'(cfg_data[31:0]);
                REG_CURRENT_LIMIT:     current_limit_reg <= cfg_data[14:0];
                REG_PROP_GAIN:         prop_gain_reg     <= cfg_data[14:0];
                REG_INTEG_GAIN:        integ_gain_reg    <= cfg_data[14:0];
                REG_LOOP_DIVIDER:      loop_divider_reg  <= cfg_data[15:0];
                REG_POSITION_DEADBAND: deadband_reg      <= cfg_data[15:0];
                REG_ZERO_SNAP:         zero_snap_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Control state and loop state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            last_pos_reg <= '0;
            filt_reg     <= '0;
            integ_reg    <= '0;
            held_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_xfer) begin
                tick_reg <= run_tick ? 16'd0 : tick_inc;
            end
            if (state_reg == ST_DELTA) begin
                last_pos_reg <= pos_reg;
            end
            if (state_reg == ST_FILT2) begin
                filt_reg <= fnew;
                if (!speed_mode_on_reg) begin
                    integ_reg <= '0;
                    held_reg  <= '0;
                end
            end
            if (state_reg == ST_AW && keep) begin
                integ_reg <= inew_reg;
            end
            if (state_reg == ST_OUT) begin
                held_reg <= out_clamped;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Work and output payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            pos_reg <= s_rotor_position;
            ran_reg <= run_tick;
        end
        if (mul_sel != MUL_NONE) begin
            prod_reg <= 51'(mul_a) * 51'(mul_b);
        end
        case (state_reg)
            ST_DELTA: begin
                ctrl_reg <= ctrl;
                dead_reg <= dead;
            end
            ST_SAT:   raw_reg  <= dead_reg ? 32'sd0 : raw_sat;
            ST_FILT1: step_reg <= shift_sym(diff34, FILTER_SHIFT);
            ST_ERR1:  err_reg  <= err_clamped;
            ST_ERR2:  es_reg   <= es_clamped;
            ST_PMUL:  inew_reg <= inew;
            ST_IMUL:  p_reg    <= prod_reg[31:0];
            default: ;
        endcase
        if (out_load) begin
            m_qref_reg  <= held_reg;
            m_speed_reg <= filt_reg;
            m_ran_reg   <= ran_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_q_current_ref  = m_qref_reg;
    assign m_speed_estimate = m_speed_reg;
    assign m_loop_ran       = m_ran_reg;

    // An input transfer always starts the sequencer.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg != ST_IDLE)
        else $error("sequencer did not leave idle after an input transfer");

    // A loop tick always restarts the divider count.
    a_tick_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DELTA |-> tick_reg == '0)
        else $error("tick divider not cleared on a loop tick");

    // The integrator and held output stay within the symmetric output range.
    a_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        integ_reg != 16'sh8000 && held_reg != 16'sh8000)
        else $error("integrator or held reference left the symmetric range");

    // The filtered speed stays inside the saturated 32-bit range.
    a_filt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        filt_reg != 32'sh8000_0000)
        else $error("filtered speed reached the negative full scale");

    // Outside speed mode a finished loop tick leaves the output cleared.
    a_mode_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILT2 && !speed_mode_on_reg) |=> held_reg == '0)
        else $error("held reference not cleared outside speed mode");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for motor_speed_pi_loop_core: speed estimate, filter and
// PI loop checked per control tick against an in-bench predictor. Depends on mspi_pkg.

module testbench;
    import mspi_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 32;
    localparam int PHASE_TICKS   = 50;

    typedef struct packed {
        logic signed [15:0] q_ref;
        logic signed [31:0] speed;
        logic               ran;
    } tick_result_t;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic signed [31:0]    s_rotor_position = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic signed [15:0]    m_q_current_ref;
    logic signed [31:0]    m_speed_estimate;
    logic                  m_loop_ran;
    logic                  cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;

    // Predictor copy of the loop settings (reset values).
    logic        mode_on  = 1'b0;
    longint      target   = 0;
    longint      i_limit  = 0;
    longint      kp       = 0;
    longint      ki       = 0;
    logic [15:0] divider  = 16'd10;
    longint      deadband = 0;
    longint      snap     = 0;

    // Predictor copy of the loop state.
    logic [15:0] tick_count    = '0;
    logic [31:0] prev_position = '0;
    longint      speed_filt    = 0;
    longint      integ_acc     = 0;
    longint      held_ref      = 0;

    logic [31:0]  pending_ticks[$];
    tick_result_t expected_ticks[$];
    logic         in_taken     = 1'b0;
    int unsigned  src_idle_pct = 0;
    int unsigned  snk_idle_pct = 0;
    int           error_count  = 0;
    int           cycle_count  = 0;

    motor_speed_pi_loop_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rotor_position (s_rotor_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_q_current_ref  (m_q_current_ref),
        .m_speed_estimate (m_speed_estimate),
        .m_loop_ran       (m_loop_ran),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Shifts the magnitude and keeps the sign, so the result rounds toward zero.
    function automatic longint shift_toward_zero(input longint v, input int sh);
        return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
    endfunction

    task automatic predict_loop_tick(input logic [31:0] pos);
        logic signed [31:0] step32;
        longint             delta, raw, err, es, inew, unc;
        tick_result_t       r;
        tick_count = tick_count + 16'd1;
        r.ran = 1'b0;
        if (tick_count >= divider) begin
            tick_count = '0;
            r.ran = 1'b1;
            step32 = pos - prev_position;
            delta = longint'(step32) * SENSOR_DIRECTION;
            prev_position = pos;
            if (delta <= deadband && delta >= -deadband) begin
                raw = 0;
            end else begin
                raw = clip(delta * SPEED_SCALE, SAT32);
            end
            speed_filt = clip(speed_filt + shift_toward_zero(raw - speed_filt, FILTER_SHIFT),
                              SAT32);
            if (speed_filt <= snap && speed_filt >= -snap) begin
                speed_filt = 0;
            end
            if (mode_on) begin
                err  = clip(target - speed_filt, ERROR_LIMIT);
                es   = clip(shift_toward_zero(err, ERROR_SHIFT), OUT_MAX);
                inew = clip(integ_acc + es, OUT_MAX);
                unc  = kp * es + ki * inew;
                // Keep the new integral unless it would push further into the clamp.
                if (clip(unc, i_limit) == unc || ki == 0 ||
                    (unc > i_limit && es < 0) || (unc < -i_limit && es > 0)) begin
                    integ_acc = inew;
                end
                held_ref = clip(kp * es + ki * integ_acc, i_limit);
            end else begin
                held_ref  = 0;
                integ_acc = 0;
            end
        end
        r.q_ref = held_ref[15:0];
        r.speed = speed_filt[31:0];
        expected_ticks.push_back(r);
    endtask

    task automatic write_reg(input mspi_reg_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SPEED_MODE_ON:     mode_on  = val[0];
            REG_SPEED_TARGET:      target   = longint'(signed'(val));
            REG_CURRENT_LIMIT:     i_limit  = longint'(val[14:0]);
            REG_PROP_GAIN:         kp       = longint'(val[14:0]);
            REG_INTEG_GAIN:        ki       = longint'(val[14:0]);
            REG_LOOP_DIVIDER:      divider  = val[15:0];
            REG_POSITION_DEADBAND: deadband = longint'(val[15:0]);
            REG_ZERO_SNAP:         snap     = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic load_loop_settings(input logic mode, input logic [31:0] tgt,
                                      input int unsigned lim, input int unsigned p_gain,
                                      input int unsigned i_gain, input int unsigned div,
                                      input int unsigned db, input int unsigned snp);
        write_reg(REG_SPEED_MODE_ON, {31'd0, mode});
        write_reg(REG_SPEED_TARGET, tgt);
        write_reg(REG_CURRENT_LIMIT, 32'(lim));
        write_reg(REG_PROP_GAIN, 32'(p_gain));
        write_reg(REG_INTEG_GAIN, 32'(i_gain));
        write_reg(REG_LOOP_DIVIDER, 32'(div));
        write_reg(REG_POSITION_DEADBAND, 32'(db));
        write_reg(REG_ZERO_SNAP, 32'(snp));
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // Waits until every tick is transferred and answered, then lets the block settle.
    task automatic drain_ticks();
        while (pending_ticks.size() != 0 || s_valid || expected_ticks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly a typical value, now and then zero or the top of the range.
    function automatic int unsigned pick_setting(input int unsigned top,
                                                 input int unsigned typical);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return top;
        return $urandom_range(typical);
    endfunction

    always @(negedge aclk) begin : driver
        if (!s_valid || in_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_valid          <= 1'b1;
                s_rotor_position <= pending_ticks.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin : monitor
        tick_result_t want;
        in_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_loop_tick(s_rotor_position);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_ticks.size() == 0) begin
                $display("%0t: unexpected result transfer: q_current_ref %0d speed %0d ran %0b",
                         $time, m_q_current_ref, m_speed_estimate, m_loop_ran);
                error_count++;
            end else begin
                want = expected_ticks.pop_front();
                if (m_q_current_ref !== want.q_ref) begin
                    $display("%0t: q_current_ref mismatch: expected %0d, got %0d",
                             $time, want.q_ref, m_q_current_ref);
                    error_count++;
                end
                if (m_speed_estimate !== want.speed) begin
                    $display("%0t: speed_estimate mismatch: expected %0d, got %0d",
                             $time, want.speed, m_speed_estimate);
                    error_count++;
                end
                if (m_loop_ran !== want.ran) begin
                    $display("%0t: loop_ran mismatch: expected %0b, got %0b",
                             $time, want.ran, m_loop_ran);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] pos;
        int          vel;
        int unsigned sel;
        int unsigned div;
        bit          noise;
        longint      tgt;
        src_idle_pct = 22;
        snk_idle_pct = 61;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Reset settings: divider of ten and speed mode off, so these ticks are all skipped.
        for (int i = 1; i <= 8; i++) pending_ticks.push_back(32'(i * 100));
        drain_ticks();
        // A divider below the running count makes the next tick run the loop.
        write_reg(REG_LOOP_DIVIDER, 32'd3);
        @(negedge aclk) cfg_we <= 1'b0;
        pending_ticks.push_back(32'd900);
        pending_ticks.push_back(32'd1000);
        drain_ticks();

        // Divider zero, full gains and limit, position extremes and wrapping deltas.
        load_loop_settings(1'b1, 32'h7FFF_FFFF, 32767, 32767, 32767, 0, 0, 0);
        pending_ticks = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                          32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        drain_ticks();
        // Error reverses out of saturation, which lets the integrator unwind.
        load_loop_settings(1'b1, 32'h8000_0001, 32767, 32767, 32767, 0, 0, 0);
        pending_ticks = '{32'd0, 32'd10, 32'd20};
        drain_ticks();
        // Zero current limit, widest deadband and snap window.
        load_loop_settings(1'b1, 32'd1000, 0, 100, 0, 1, 65535, 65535);
        pending_ticks = '{32'd0, 32'd70000, 32'd140000, 32'd145000};
        drain_ticks();

        pos = $urandom();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES / 3) begin
                src_idle_pct = 61;
                snk_idle_pct = 22;
            end else if (phase == 2 * RANDOM_PHASES / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            sel = $urandom_range(99);
            noise = 1'b0;
            if (sel < 55) begin
                vel = int'($urandom_range(600)) - 300;
            end else if (sel < 75) begin
                vel = int'($urandom_range(4_000_000)) - 2_000_000;
            end else if (sel < 85) begin
                vel = 0;
            end else begin
                vel = 0;
                noise = 1'b1;
            end

            sel = $urandom_range(99);
            if (sel < 40) begin
                tgt = clip(longint'(vel) * SPEED_SCALE + longint'($urandom_range(40000)) - 20000,
                           SAT32);
            end else if (sel < 50) begin
                tgt = SAT32;
            end else if (sel < 60) begin
                tgt = -SAT32;
            end else begin
                tgt = longint'($urandom_range(800000)) - 400000;
            end

            sel = $urandom_range(19);
            if (sel == 0) begin
                div = 0;
            end else if (sel == 1) begin
                div = 65535;
            end else if (sel < 10) begin
                div = 1;
            end else if (sel < 15) begin
                div = $urandom_range(4, 2);
            end else begin
                div = $urandom_range(12, 5);
            end

            load_loop_settings($urandom_range(9) != 0, 32'(tgt),
                               pick_setting(32767, 32767), pick_setting(32767, 200),
                               pick_setting(32767, 40), div,
                               pick_setting(65535, 100), pick_setting(65535, 3000));

            if ($urandom_range(4) == 0) pos = $urandom();
            for (int i = 0; i < PHASE_TICKS; i++) begin
                // Mostly steady rotation with jitter; the rest are jumps or noise.
                if (noise || $urandom_range(99) < 8) begin
                    pos = $urandom();
                end else begin
                    pos = pos + 32'(vel + int'($urandom_range(6)) - 3);
                end
                pending_ticks.push_back(pos);
            end
            drain_ticks();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mspi_pkg.sv
rtl/motor_speed_pi_loop_core.sv
tb/testbench.sv
